FILE: rtl/kss_pkg.sv
// Package with shared types for the k-th smallest stream select unit.
`timescale 1ns / 1ps
package kss_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CHK_CMP,
        ST_INS_RD,
        ST_INS_CMP,
        ST_FIN,
        ST_FIN_OUT
    } kss_state_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_KM1,
        RD_POSM1
    } kss_rd_sel_t;

    typedef struct packed {
        logic        load;
        logic        ins_tail;
        logic        ins_replace;
        kss_rd_sel_t rd_sel;
        logic        wr_shift;
        logic        wr_val;
        logic        out_load;
        logic        clr_count;
    } kss_cmd_t;

    typedef struct packed {
        logic count_lt_k;
        logic rdata_gt_v;
        logic pos_zero;
        logic last;
        logic out_busy;
    } kss_status_t;

endpackage

FILE: rtl/kss_in_if.sv
// Valid/ready channel carrying one input transaction.
`timescale 1ns / 1ps
interface kss_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data_value;
    logic               last_item;

    modport source (output valid, output data_value, output last_item, input ready);
    modport sink (input valid, input data_value, input last_item, output ready);
endinterface

FILE: rtl/kss_out_if.sv
// Valid/ready channel carrying one result transaction.
`timescale 1ns / 1ps
interface kss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] kth_value;
    logic               status;

    modport source (output valid, output kth_value, output status, input ready);
    modport sink (input valid, input kth_value, input status, output ready);
endinterface

FILE: rtl/kss_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

FILE: rtl/kss_datapath.sv
// Datapath: rank register, kept-value memory, insertion pointer and result register.
`timescale 1ns / 1ps
module kss_datapath #(
    parameter int K_MAX = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    input  kss_pkg::kss_cmd_t     cmd,
    output kss_pkg::kss_status_t  stat,
    input  logic signed [31:0]    data_value,
    input  logic                  last_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [31:0]    kth_value,
    output logic                  status
);
    import kss_pkg::*;

    localparam int AW = (K_MAX > 1) ? $clog2(K_MAX) : 1;
    localparam int CW = $clog2(K_MAX + 1);

    logic [6:0]         rank_reg;
    logic [CW-1:0]      k_reg;
    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      pos_reg;
    logic signed [31:0] v_reg;
    logic               last_reg;
    logic               out_valid_reg;
    logic signed [31:0] kth_reg;
    logic               status_reg;

    logic [31:0]        rank_ext;
    logic [31:0]        k_wide;
    logic [CW-1:0]      k_eff;
    logic [CW-1:0]      km1;
    logic [31:0]        rdata;
    logic               re;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [31:0]        wdata;

    always_comb
    begin
        rank_ext = {25'd0, rank_reg};
        if (rank_ext == 32'd0)
        begin
            k_wide = 32'd1;
        end
        else if (rank_ext > 32'(K_MAX))
        begin
            k_wide = 32'(K_MAX);
        end
        else
        begin
            k_wide = rank_ext;
        end
        k_eff = k_wide[CW-1:0];
        km1   = k_reg - CW'(1);
    end

    always_comb
    begin
        re    = 1'b0;
        raddr = km1[AW-1:0];
        case (cmd.rd_sel)
            RD_KM1:
            begin
                re    = 1'b1;
                raddr = km1[AW-1:0];
            end
            RD_POSM1:
            begin
                re    = 1'b1;
                raddr = pos_reg - AW'(1);
            end
            default:
            begin
                re = 1'b0;
            end
        endcase
        we    = cmd.wr_shift | cmd.wr_val;
        waddr = pos_reg;
        wdata = cmd.wr_shift ? rdata : v_reg;
    end

    kss_ram #(
        .WIDTH (32),
        .DEPTH (K_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg      <= 7'd1;
            count_reg     <= '0;
            k_reg         <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rank_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                k_reg     <= k_eff;
                count_reg <= (count_reg > k_eff) ? k_eff : count_reg;
            end
            else if (cmd.ins_replace)
            begin
                count_reg <= km1;
            end
            else if (cmd.wr_val)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            v_reg    <= data_value;
            last_reg <= last_item;
        end
        if (cmd.ins_tail)
        begin
            pos_reg <= count_reg[AW-1:0];
        end
        else if (cmd.ins_replace)
        begin
            pos_reg <= km1[AW-1:0];
        end
        else if (cmd.wr_shift)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.out_load)
        begin
            if (count_reg >= k_reg)
            begin
                kth_reg    <= $signed(rdata);
                status_reg <= 1'b0;
            end
            else
            begin
                kth_reg    <= '0;
                status_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.count_lt_k = count_reg < k_reg;
        stat.rdata_gt_v = $signed(rdata) > v_reg;
        stat.pos_zero   = pos_reg == '0;
        stat.last       = last_reg;
        stat.out_busy   = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign kth_value = kth_reg;
    assign status    = status_reg;
endmodule

FILE: rtl/kss_ctrl.sv
// Controller state machine sequencing the check, insertion and result steps.
`timescale 1ns / 1ps
module kss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  kss_pkg::kss_status_t stat,
    output kss_pkg::kss_cmd_t    cmd
);
    import kss_pkg::*;

    kss_state_t state_reg;
    kss_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.count_lt_k)
                begin
                    cmd.ins_tail = 1'b1;
                    state_next   = ST_INS_RD;
                end
                else
                begin
                    cmd.rd_sel = RD_KM1;
                    state_next = ST_CHK_CMP;
                end
            end
            ST_CHK_CMP:
            begin
                if (stat.rdata_gt_v)
                begin
                    cmd.ins_replace = 1'b1;
                    state_next      = ST_INS_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_INS_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.wr_val = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.rd_sel = RD_POSM1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (stat.rdata_gt_v)
                begin
                    cmd.wr_shift = 1'b1;
                    state_next   = ST_INS_RD;
                end
                else
                begin
                    cmd.wr_val = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!stat.last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    if (!stat.count_lt_k)
                    begin
                        cmd.rd_sel = RD_KM1;
                    end
                    state_next = ST_FIN_OUT;
                end
            end
            ST_FIN_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.clr_count = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/kth_smallest_stream_select_unit.sv
// Top level of the k-th smallest stream select unit.
//
//   channel  | dir | payload                  | handshake
//   in_ch    | in  | data_value, last_item    | valid/ready
//   out_ch   | out | kth_value, status        | valid/ready
//   cfg      | in  | cfg_wdata (rank_k)       | cfg_we
//
// An item is checked against the kept count or the k-th kept value and, if kept, moves past
// each larger kept value (a read, then a shift write) during sorted insertion into the memory.
// A last item also loads the k-th kept value into the result register.
// Reset clears the kept count and sets rank_k to 1; the memory needs no clearing.
// A held result stalls only the next last item; other items keep flowing.
`timescale 1ns / 1ps
module kth_smallest_stream_select_unit #(
    parameter int K_MAX = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [6:0] cfg_wdata,
    kss_in_if.sink    in_ch,
    kss_out_if.source out_ch
);
    import kss_pkg::*;

    kss_cmd_t    cmd;
    kss_status_t stat;

    kss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kss_datapath #(
        .K_MAX (K_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (cmd),
        .stat       (stat),
        .data_value (in_ch.data_value),
        .last_item  (in_ch.last_item),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .kth_value  (out_ch.kth_value),
        .status     (out_ch.status)
    );
endmodule

FILE: rtl/kss_checker.sv
// Port-level checker for the k-th smallest stream select unit, with its bind.
`timescale 1ns / 1ps
module kss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] kth_value,
    input logic        status
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(kth_value) && $stable(status))
        else $error("result payload changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> kth_value == 32'd0)
        else $error("error result carries a nonzero value");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while one is in work");
endmodule

bind kth_smallest_stream_select_unit kss_checker u_kss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .kth_value (out_ch.kth_value),
    .status    (out_ch.status)
);

FILE: test/testbench.sv
// Self-checking testbench for the k-th smallest stream select unit.
`timescale 1ns / 1ps
module testbench;
    import kss_pkg::*;

    localparam int KMAX = 64;
    localparam int SETTLE = 2 * KMAX + 16;
    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [6:0] cfg_wdata;

    kss_in_if in_ch ();
    kss_out_if out_ch ();

    kth_smallest_stream_select_unit #(.K_MAX(KMAX)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    logic signed [31:0] kept_vals [KMAX];
    int unsigned kept_n;
    logic [6:0] rank_reg;
    logic signed [31:0] want_value [$];
    logic want_status [$];
    int errors;
    int items_sent;
    int results_seen;
    int streams_sent;
    int idle_cycles;
    bit sink_eager;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int unsigned eff_rank();
        int unsigned k;
        k = rank_reg;
        if (k == 0)
            k = 1;
        if (k > KMAX)
            k = KMAX;
        return k;
    endfunction

    function automatic void insert_kept(logic signed [31:0] v);
        int unsigned pos;
        pos = kept_n;
        while (pos > 0 && kept_vals[pos - 1] > v)
        begin
            kept_vals[pos] = kept_vals[pos - 1];
            pos--;
        end
        kept_vals[pos] = v;
        kept_n++;
    endfunction

    function automatic void select_step(logic signed [31:0] v, logic last);
        int unsigned k;
        k = eff_rank();
        if (kept_n > k)
            kept_n = k;
        if (kept_n < k)
            insert_kept(v);
        else if (v < kept_vals[k - 1])
        begin
            kept_n = k - 1;
            insert_kept(v);
        end
        if (last)
        begin
            if (kept_n >= k)
            begin
                want_value.push_back(kept_vals[k - 1]);
                want_status.push_back(1'b0);
            end
            else
            begin
                want_value.push_back(32'sd0);
                want_status.push_back(1'b1);
            end
            kept_n = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(logic signed [31:0] v, logic last, bit no_gap);
        int gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_value <= v;
        in_ch.last_item <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        select_step(v, last);
        items_sent++;
        if (last)
            streams_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (want_value.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_rank(logic [6:0] k);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
        rank_reg = k;
    endtask

    function automatic logic signed [31:0] rand_value(int mode);
        case (mode)
            0: return $signed($urandom());
            1: return $signed($urandom_range(7)) - 3;
            2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    task automatic send_stream(int len, int mode);
        bit no_gap;
        no_gap = ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++)
            send_item(rand_value(mode), i == len - 1, no_gap);
    endtask

    task automatic test_extremes();
        write_rank(7'd1);
        send_item(32'sh7fffffff, 1'b1, 1'b0);
        send_item(32'sh80000000, 1'b1, 1'b0);
        send_item(32'sh00000000, 1'b0, 1'b0);
        send_item(32'shffffffff, 1'b1, 1'b0);
        write_rank(7'd3);
        send_item(32'sh7fffffff, 1'b0, 1'b0);
        send_item(32'sh80000000, 1'b0, 1'b0);
        send_item(32'sh80000000, 1'b0, 1'b0);
        send_item(32'sh7fffffff, 1'b1, 1'b0);
        send_item(32'sd5, 1'b0, 1'b1);
        send_item(32'sd5, 1'b1, 1'b1);
        send_item(32'sd9, 1'b0, 1'b1);
        send_item(32'sd2, 1'b0, 1'b1);
        send_item(32'sd9, 1'b0, 1'b1);
        send_item(32'sd9, 1'b1, 1'b1);
    endtask

    task automatic test_rank_limits();
        write_rank(7'd0);
        send_stream(4, 0);
        write_rank(7'd127);
        send_stream(70, 0);
        send_stream(10, 0);
        write_rank(7'd64);
        send_stream(64, 3);
        send_stream(63, 0);
    endtask

    task automatic test_rank_lowered();
        write_rank(7'd8);
        for (int i = 0; i < 10; i++)
            send_item(rand_value(3), 1'b0, 1'b0);
        write_rank(7'd3);
        send_item(rand_value(3), 1'b0, 1'b0);
        send_item(rand_value(3), 1'b1, 1'b0);
    endtask

    task automatic test_random();
        int k;
        while (items_sent < 1400)
        begin
            case ($urandom_range(5))
                0: k = 1;
                1: k = KMAX;
                2: k = $urandom_range(127, 65);
                default: k = $urandom_range(12, 1);
            endcase
            write_rank(7'(k));
            repeat ($urandom_range(8, 3))
            begin
                int len;
                if (items_sent >= 1400)
                    break;
                if ($urandom_range(9) == 0)
                    len = $urandom_range(k > 1 ? k - 1 : 1, 1);
                else
                    len = $urandom_range((k > KMAX ? KMAX : k) + 8, 1);
                send_stream(len, $urandom_range(3));
            end
        end
    endtask

    always @(negedge clk)
    begin
        if ($urandom_range(49) == 0)
            sink_eager <= ~sink_eager;
        if (sink_eager)
            out_ch.ready <= 1'b1;
        else
            out_ch.ready <= (pick_gap() == 0);
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (want_value.size() == 0)
                report_mismatch("result with none expected");
            else
            begin
                if (out_ch.kth_value !== want_value[0])
                    report_mismatch($sformatf("kth_value %0d, expected %0d",
                        out_ch.kth_value, want_value[0]));
                if (out_ch.status !== want_status[0])
                    report_mismatch($sformatf("status %0b, expected %0b",
                        out_ch.status, want_status[0]));
                void'(want_value.pop_front());
                void'(want_status.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
            $display("kth_smallest_stream_select_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 7'd0;
        in_ch.valid = 1'b0;
        in_ch.data_value = 32'sd0;
        in_ch.last_item = 1'b0;
        out_ch.ready = 1'b0;
        sink_eager = 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        streams_sent = 0;
        idle_cycles = 0;
        kept_n = 0;
        rank_reg = 7'd1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_extremes();
        test_rank_limits();
        test_rank_lowered();
        test_random();
        wait_idle();

        if (want_value.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", want_value.size()));
        $display("Sent %0d values in %0d streams and checked %0d results.",
            items_sent, streams_sent, results_seen);
        if (errors == 0)
            $display("kth_smallest_stream_select_unit: match");
        else
            $display("kth_smallest_stream_select_unit: mismatch");
        $finish;
    end
endmodule
